// ===== rtl/baro_comp_pkg.sv =====
package baro_comp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // accepting edge to result strobe, in cycles
    localparam int LATENCY = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS_BASE   = 3'd0,
        REG_OFF_BASE    = 3'd1,
        REG_SENS_TEMPCO = 3'd2,
        REG_OFF_TEMPCO  = 3'd3,
        REG_TEMP_REF    = 3'd4,
        REG_TEMP_COEFF  = 3'd5
    } cfg_reg_t;

    // temperature thresholds in hundredths of a degree
    localparam logic signed [20:0] TEMP_MID = 21'sd2000;
    localparam logic signed [20:0] TEMP_LOW = -21'sd1500;

    // bias that turns the arithmetic shift by 23 into truncation toward zero
    localparam logic signed [41:0] TEMP_DIV_BIAS = 42'sd8388607;

    // second-order weights
    localparam logic [5:0] OFF2_A  = 6'd61;
    localparam logic [4:0] SENS2_A = 5'd29;
    localparam logic [4:0] OFF2_B  = 5'd17;
    localparam logic [3:0] SENS2_B = 4'd9;

endpackage

// ===== rtl/baro_pressure_temp_compensation.sv =====
// done flags the cycle in which the results of an accepted start are on the outputs.
// Throughput: one sample pair per cycle; nine register stages run in lock step.
// busy is high only while rst_n is low and for the first edge after release;
// the result side has no back-pressure, so nothing ever stalls.
// Reset clears the calibration registers to zero and the pipeline valid bits.
module baro_pressure_temp_compensation (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [23:0]                            raw_pressure,
    input  logic [23:0]                            raw_temperature,
    input  logic                                   cfg_we,
    input  logic [baro_comp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [baro_comp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                                   done,
    output logic signed [18:0]                     temperature_centi,
    output logic signed [31:0]                     pressure_pa
);

    // calibration registers
    logic [15:0] sens_base_reg;
    logic [15:0] off_base_reg;
    logic [15:0] sens_tempco_reg;
    logic [15:0] off_tempco_reg;
    logic [15:0] temp_ref_reg;
    logic [15:0] temp_coeff_reg;

    logic                                   busy_reg;
    logic [baro_comp_pkg::LATENCY-1:0]      v_reg;
    logic [baro_comp_pkg::LATENCY-1:0]      v_next;
    logic                                   accept;

    // stage 1
    logic signed [24:0] dt_next, dt_reg;
    logic [23:0]        d1_s1_reg;
    // stage 2
    logic signed [41:0] temp_prod_next, temp_prod_reg;
    logic signed [41:0] off_prod_next, off_prod_reg;
    logic signed [41:0] sens_prod_next, sens_prod_reg;
    logic signed [49:0] dt_sq_full;
    logic [47:0]        dt_sq_reg;
    logic [23:0]        d1_s2_reg;
    // stage 3
    logic signed [41:0] temp_adj;
    logic [18:0]        temp_q;
    logic signed [20:0] temp1_next, temp1_reg;
    logic signed [35:0] off1_next, off1_s3_reg;
    logic signed [35:0] sens1_next, sens1_s3_reg;
    logic [49:0]        dt_sq3;
    logic [50:0]        dt_sq5;
    logic [16:0]        t2a_reg;
    logic [12:0]        t2b_reg;
    logic [23:0]        d1_s3_reg;
    // stage 4
    logic signed [20:0] a_val, b_val, t2_val;
    logic signed [41:0] asq_full, bsq_full;
    logic [34:0]        asq_reg, bsq_reg;
    logic signed [20:0] temp_fin_next, temp_s4_reg;
    logic               lt_mid_reg, lt_low_reg;
    logic signed [35:0] off1_s4_reg, sens1_s4_reg;
    logic [23:0]        d1_s4_reg;
    // stage 5
    logic [40:0]        off2_a;
    logic [39:0]        off2_b;
    logic [39:0]        sens2_a;
    logic [38:0]        sens2_b;
    logic [40:0]        off2_next, off2_reg;
    logic [39:0]        sens2_next, sens2_reg;
    logic signed [35:0] off1_s5_reg, sens1_s5_reg;
    logic signed [20:0] temp_s5_reg;
    logic [23:0]        d1_s5_reg;
    // stage 6
    logic signed [41:0] off_next, off_s6_reg;
    logic signed [41:0] sens_next, sens_s6_reg;
    logic signed [20:0] temp_s6_reg;
    logic [23:0]        d1_s6_reg;
    // stage 7: pressure product split in two partial products
    logic [44:0]        plo_next, plo_reg;
    logic signed [45:0] phi_next, phi_reg;
    logic signed [41:0] off_s7_reg;
    logic signed [20:0] temp_s7_reg;
    // stage 8
    logic signed [46:0] s1_next, s1_reg;
    logic signed [41:0] off_s8_reg;
    logic signed [20:0] temp_s8_reg;
    // stage 9
    logic signed [47:0] p_diff;
    logic signed [31:0] pressure_next, pressure_reg;
    logic signed [18:0] temperature_reg;

    assign accept = start && !busy_reg;
    assign v_next = {v_reg[baro_comp_pkg::LATENCY-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b1;
            v_reg           <= '0;
            sens_base_reg   <= '0;
            off_base_reg    <= '0;
            sens_tempco_reg <= '0;
            off_tempco_reg  <= '0;
            temp_ref_reg    <= '0;
            temp_coeff_reg  <= '0;
        end
        else
        begin
            busy_reg <= 1'b0;
            v_reg    <= v_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    baro_comp_pkg::REG_SENS_BASE:   sens_base_reg   <= cfg_data;
                    baro_comp_pkg::REG_OFF_BASE:    off_base_reg    <= cfg_data;
                    baro_comp_pkg::REG_SENS_TEMPCO: sens_tempco_reg <= cfg_data;
                    baro_comp_pkg::REG_OFF_TEMPCO:  off_tempco_reg  <= cfg_data;
                    baro_comp_pkg::REG_TEMP_REF:    temp_ref_reg    <= cfg_data;
                    baro_comp_pkg::REG_TEMP_COEFF:  temp_coeff_reg  <= cfg_data;
                    default:                        ;
                endcase
            end
        end
    end

    always_comb
    begin
        // stage 1: dT
        dt_next = $signed({1'b0, raw_temperature}) - $signed({1'b0, temp_ref_reg, 8'h00});

        // stage 2: the four products on dT
        temp_prod_next = dt_reg * $signed({1'b0, temp_coeff_reg});
        off_prod_next  = dt_reg * $signed({1'b0, off_tempco_reg});
        sens_prod_next = dt_reg * $signed({1'b0, sens_tempco_reg});
        dt_sq_full     = dt_reg * dt_reg;

        // stage 3: first-order TEMP, OFF, SENS and both T2 candidates
        temp_adj   = temp_prod_reg + (temp_prod_reg[41] ? baro_comp_pkg::TEMP_DIV_BIAS : 42'sd0);
        temp_q     = temp_adj[41:23];
        temp1_next = $signed({{2{temp_q[18]}}, temp_q}) + baro_comp_pkg::TEMP_MID;
        off1_next  = $signed({3'b000, off_base_reg, 17'h00000})
                   + $signed(off_prod_reg[41:6]);
        sens1_next = $signed({4'h0, sens_base_reg, 16'h0000})
                   + $signed({sens_prod_reg[41], sens_prod_reg[41:7]});
        dt_sq3     = {2'b00, dt_sq_reg} + {1'b0, dt_sq_reg, 1'b0};
        dt_sq5     = {3'b000, dt_sq_reg} + {1'b0, dt_sq_reg, 2'b00};

        // stage 4: squares of the distances to both thresholds, final TEMP
        a_val    = temp1_reg - baro_comp_pkg::TEMP_MID;
        b_val    = temp1_reg - baro_comp_pkg::TEMP_LOW;
        asq_full = a_val * a_val;
        bsq_full = b_val * b_val;
        t2_val   = (temp1_reg < baro_comp_pkg::TEMP_MID) ? $signed({4'h0, t2a_reg})
                                                         : $signed({8'h00, t2b_reg});
        temp_fin_next = temp1_reg - t2_val;

        // stage 5: OFF2 and SENS2, all terms non-negative
        off2_a  = asq_reg * baro_comp_pkg::OFF2_A;
        off2_b  = bsq_reg * baro_comp_pkg::OFF2_B;
        sens2_a = asq_reg * baro_comp_pkg::SENS2_A;
        sens2_b = bsq_reg * baro_comp_pkg::SENS2_B;
        off2_next  = '0;
        sens2_next = '0;
        if (lt_mid_reg)
        begin
            off2_next  = {4'h0, off2_a[40:4]} + (lt_low_reg ? {1'b0, off2_b} : 41'd0);
            sens2_next = {4'h0, sens2_a[39:4]} + (lt_low_reg ? {1'b0, sens2_b} : 40'd0);
        end

        // stage 6: corrected OFF and SENS
        off_next  = $signed({{6{off1_s5_reg[35]}}, off1_s5_reg}) - $signed({1'b0, off2_reg});
        sens_next = $signed({{6{sens1_s5_reg[35]}}, sens1_s5_reg}) - $signed({2'b00, sens2_reg});

        // stage 7: D1 * SENS as low (unsigned) and high (signed) halves
        plo_next = d1_s6_reg * sens_s6_reg[20:0];
        phi_next = $signed({1'b0, d1_s6_reg}) * $signed(sens_s6_reg[41:21]);

        // stage 8: floor((D1 * SENS) / 2^21) = high part + floor(low part / 2^21)
        s1_next = $signed({phi_reg[45], phi_reg}) + $signed({23'h000000, plo_reg[44:21]});

        // stage 9
        p_diff        = $signed({s1_reg[46], s1_reg}) - $signed({{6{off_s8_reg[41]}}, off_s8_reg});
        pressure_next = p_diff[46:15];
    end

    always_ff @(posedge clk)
    begin
        dt_reg        <= dt_next;
        d1_s1_reg     <= raw_pressure;

        temp_prod_reg <= temp_prod_next;
        off_prod_reg  <= off_prod_next;
        sens_prod_reg <= sens_prod_next;
        dt_sq_reg     <= dt_sq_full[47:0];
        d1_s2_reg     <= d1_s1_reg;

        temp1_reg     <= temp1_next;
        off1_s3_reg   <= off1_next;
        sens1_s3_reg  <= sens1_next;
        t2a_reg       <= dt_sq3[49:33];
        t2b_reg       <= dt_sq5[50:38];
        d1_s3_reg     <= d1_s2_reg;

        asq_reg       <= asq_full[34:0];
        bsq_reg       <= bsq_full[34:0];
        temp_s4_reg   <= temp_fin_next;
        lt_mid_reg    <= temp1_reg < baro_comp_pkg::TEMP_MID;
        lt_low_reg    <= temp1_reg < baro_comp_pkg::TEMP_LOW;
        off1_s4_reg   <= off1_s3_reg;
        sens1_s4_reg  <= sens1_s3_reg;
        d1_s4_reg     <= d1_s3_reg;

        off2_reg      <= off2_next;
        sens2_reg     <= sens2_next;
        off1_s5_reg   <= off1_s4_reg;
        sens1_s5_reg  <= sens1_s4_reg;
        temp_s5_reg   <= temp_s4_reg;
        d1_s5_reg     <= d1_s4_reg;

        off_s6_reg    <= off_next;
        sens_s6_reg   <= sens_next;
        temp_s6_reg   <= temp_s5_reg;
        d1_s6_reg     <= d1_s5_reg;

        plo_reg       <= plo_next;
        phi_reg       <= phi_next;
        off_s7_reg    <= off_s6_reg;
        temp_s7_reg   <= temp_s6_reg;

        s1_reg        <= s1_next;
        off_s8_reg    <= off_s7_reg;
        temp_s8_reg   <= temp_s7_reg;

        pressure_reg    <= pressure_next;
        temperature_reg <= temp_s8_reg[18:0];
    end

    assign busy              = busy_reg;
    assign done              = v_reg[baro_comp_pkg::LATENCY-1];
    assign temperature_centi = temperature_reg;
    assign pressure_pa       = pressure_reg;

`ifndef NO_ASSERTIONS
    // an accepted beat enters the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> v_reg[0])
        else $error("accepted beat did not enter the pipeline");

    // a result strobe always traces back to a beat in the first stage
    a_done_traced: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(v_reg[0], baro_comp_pkg::LATENCY-1))
        else $error("result strobe without an accepted beat");

    // the second-order term never raises the temperature
    a_t2_lowers: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[3] |-> (temp_s4_reg <= $past(temp1_reg)))
        else $error("second-order temperature above first-order value");

    // no OFF2/SENS2 correction at or above 20 C
    a_no_corr_warm: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[4] && !$past(lt_mid_reg)) |-> (off2_reg == '0 && sens2_reg == '0))
        else $error("second-order correction applied above threshold");
`endif

endmodule
